>>> design/page_table_walker_with_tlb_assert.svh
// Assertion macros shared by the page table walker RTL.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef PAGE_TABLE_WALKER_WITH_TLB_ASSERT_SVH
`define PAGE_TABLE_WALKER_WITH_TLB_ASSERT_SVH

// same-cycle implication
`define PTW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ptw assertion failed");

// next-cycle implication
`define PTW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ptw assertion failed");

`endif

>>> design/ptw_pkg.sv
// Shared types, constants and helpers of the page table walker.
// No dependencies.
package ptw_pkg;

  localparam int CACHE_ENTRIES_DEF = 512;
  localparam int VA_W     = 48;
  localparam int PA_W     = 52;
  localparam int VPN_W    = 36;
  localparam int PFN_W    = 40;
  localparam int DATA_W   = 64;
  localparam int RED_STEP = 6;
  localparam int RED_CYC  = VPN_W / RED_STEP;
  localparam int RED_CW   = $clog2(RED_CYC);
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic OP_REQ    = 1'b0;
  localparam logic OP_DATA   = 1'b1;
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;
  localparam int   PRESENT_BIT = 0;
  localparam int   LARGE_BIT   = 7;

  typedef struct packed {
    logic              op;
    logic [VA_W-1:0]   virt_addr;
    logic [PA_W-1:0]   root_table;
    logic [DATA_W-1:0] read_data;
    logic              read_ok;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic             valid;
    logic [VPN_W-1:0] tag;
    logic [PFN_W-1:0] frame;
  } line_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_REDUCE,
    FR_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_PROBE
  } back_state_e;

  // 9-bit table index for a given walk level
  function automatic logic [8:0] level_idx(input logic [VA_W-1:0] va, input logic [1:0] lvl);
    logic [8:0] r;
    unique case (lvl)
      2'd0:    r = va[47:39];
      2'd1:    r = va[38:30];
      2'd2:    r = va[29:21];
      default: r = va[20:12];
    endcase
    return r;
  endfunction

endpackage

>>> design/ptw_front.sv
// Front end: takes command beats, computes the cache slot of a request.
// Depends on ptw_pkg.
module ptw_front #(
  parameter int CACHE_ENTRIES = ptw_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  ptw_pkg::item_t        item_i,
  input  logic                  q_full_i,
  output logic                  busy_o,
  output logic                  push_o,
  output ptw_pkg::item_t        push_item_o,
  output logic [$clog2(CACHE_ENTRIES > 1 ? CACHE_ENTRIES : 2)-1:0] push_slot_o
);
  import ptw_pkg::*;

  localparam int IDX_W = $clog2(CACHE_ENTRIES > 1 ? CACHE_ENTRIES : 2);
  localparam bit POW2  = ((1 << $clog2(CACHE_ENTRIES)) == CACHE_ENTRIES);

  front_state_e      st_q, st_d;
  item_t             hold_q, hold_d;
  logic [IDX_W-1:0]  slot_q, slot_d;
  logic [VPN_W-1:0]  vpn_q, vpn_d;
  logic [IDX_W-1:0]  rem_q, rem_d;
  logic [RED_CW-1:0] cnt_q, cnt_d;
  logic [VPN_W-1:0]  in_vpn;
  logic [IDX_W-1:0]  rem_step;

  assign in_vpn = item_i.virt_addr[VA_W-1:12];

  // restoring remainder, RED_STEP bits of the page number per cycle
  always_comb begin
    logic [IDX_W:0] t;
    logic [IDX_W-1:0] r;
    r = rem_q;
    for (int i = 0; i < RED_STEP; i++) begin
      t = {r, vpn_q[VPN_W-1-i]};
      if (t >= (IDX_W+1)'(CACHE_ENTRIES)) t = t - (IDX_W+1)'(CACHE_ENTRIES);
      r = t[IDX_W-1:0];
    end
    rem_step = r;
  end

  always_comb begin
    st_d   = st_q;
    hold_d = hold_q;
    slot_d = slot_q;
    vpn_d  = vpn_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    push_o = (st_q == FR_PUSH) && !q_full_i;
    busy_o = (st_q == FR_REDUCE) || ((st_q == FR_PUSH) && q_full_i);
    unique case (st_q)
      FR_REDUCE: begin
        vpn_d = vpn_q << RED_STEP;
        rem_d = rem_step;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == RED_CW'(RED_CYC - 1)) begin
          slot_d = rem_step;
          st_d   = FR_PUSH;
        end
      end
      FR_PUSH: begin
        if (push_o) st_d = FR_IDLE;
      end
      default: ;
    endcase
    if (accept_i) begin
      hold_d = item_i;
      hold_d.root_table[3:0] = 4'h0;
      vpn_d  = in_vpn;
      rem_d  = '0;
      cnt_d  = '0;
      slot_d = IDX_W'(in_vpn & VPN_W'(CACHE_ENTRIES - 1));
      st_d   = (POW2 || item_i.op == OP_DATA) ? FR_PUSH : FR_REDUCE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= FR_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    slot_q <= slot_d;
    vpn_q  <= vpn_d;
    rem_q  <= rem_d;
    cnt_q  <= cnt_d;
  end

  assign push_item_o = hold_q;
  assign push_slot_o = slot_q;

endmodule

>>> design/ptw_queue.sv
// Two-entry queue between front and back ends.
// Depends on ptw_pkg.
module ptw_queue #(
  parameter int CACHE_ENTRIES = ptw_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ptw_pkg::item_t        push_item_i,
  input  logic [$clog2(CACHE_ENTRIES > 1 ? CACHE_ENTRIES : 2)-1:0] push_slot_i,
  input  logic                  pop_i,
  output ptw_pkg::item_t        head_item_o,
  output logic [$clog2(CACHE_ENTRIES > 1 ? CACHE_ENTRIES : 2)-1:0] head_slot_o,
  output ptw_pkg::q_stat_t      stat_o
);
  import ptw_pkg::*;

  localparam int IDX_W = $clog2(CACHE_ENTRIES > 1 ? CACHE_ENTRIES : 2);

  item_t             item_q [QDEPTH];
  logic [IDX_W-1:0]  slot_q [QDEPTH];
  logic [QPTR_W-1:0] wp_q, rp_q;
  logic [QCNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      item_q[wp_q] <= push_item_i;
      slot_q[wp_q] <= push_slot_i;
    end
  end

  assign head_item_o  = item_q[rp_q];
  assign head_slot_o  = slot_q[rp_q];
  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

>>> design/ptw_back.sv
// Back end: translation cache memory, four-level walk sequencer, result registers.
// Depends on ptw_pkg and page_table_walker_with_tlb_assert.svh.
module ptw_back #(
  parameter int CACHE_ENTRIES = ptw_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ptw_pkg::q_stat_t      q_stat_i,
  input  ptw_pkg::item_t        head_item_i,
  input  logic [$clog2(CACHE_ENTRIES > 1 ? CACHE_ENTRIES : 2)-1:0] head_slot_i,
  output logic                  pop_o,
  output logic                  clearing_o,
  output logic                  res_valid_o,
  output logic                  kind_o,
  output logic [ptw_pkg::PA_W-1:0] mem_addr_o,
  output logic [ptw_pkg::PA_W-1:0] phys_addr_o,
  output logic                  fault_o
);
  import ptw_pkg::*;
  `include "page_table_walker_with_tlb_assert.svh"

  localparam int IDX_W = $clog2(CACHE_ENTRIES > 1 ? CACHE_ENTRIES : 2);

  line_t mem [CACHE_ENTRIES];
  line_t rd_q;

  back_state_e      st_q, st_d;
  logic [IDX_W-1:0] clr_q, clr_d;
  logic             walk_busy_q, walk_busy_d;
  logic [1:0]       lvl_q, lvl_d;
  logic [VA_W-1:0]  pend_va_q, pend_va_d;
  logic [IDX_W-1:0] pend_slot_q, pend_slot_d;
  logic [VA_W-1:0]  req_va_q, req_va_d;
  logic [PA_W-1:0]  req_root_q, req_root_d;
  logic [IDX_W-1:0] req_slot_q, req_slot_d;

  logic             res_valid_q, res_valid_d;
  logic             kind_q, kind_d;
  logic [PA_W-1:0]  mem_addr_q, mem_addr_d;
  logic [PA_W-1:0]  phys_addr_q, phys_addr_d;
  logic             fault_q, fault_d;

  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_wa, mem_ra;
  line_t            mem_wd;

  logic [DATA_W-1:0] dat;
  logic              hit;

  assign dat = head_item_i.read_data;
  assign hit = rd_q.valid && (rd_q.tag == req_va_q[VA_W-1:12]);

  always_comb begin
    st_d        = st_q;
    clr_d       = clr_q;
    walk_busy_d = walk_busy_q;
    lvl_d       = lvl_q;
    pend_va_d   = pend_va_q;
    pend_slot_d = pend_slot_q;
    req_va_d    = req_va_q;
    req_root_d  = req_root_q;
    req_slot_d  = req_slot_q;
    res_valid_d = 1'b0;
    kind_d      = kind_q;
    mem_addr_d  = mem_addr_q;
    phys_addr_d = phys_addr_q;
    fault_d     = fault_q;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = pend_slot_q;
    mem_wd      = '0;
    mem_re      = 1'b0;
    mem_ra      = head_slot_i;
    unique case (st_q)
      BK_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        clr_d  = clr_q + 1'b1;
        if (clr_q == IDX_W'(CACHE_ENTRIES - 1)) st_d = BK_IDLE;
      end
      BK_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          if (head_item_i.op == OP_REQ) begin
            mem_re      = 1'b1;
            req_va_d    = head_item_i.virt_addr;
            req_root_d  = head_item_i.root_table;
            req_slot_d  = head_slot_i;
            walk_busy_d = 1'b0;
            lvl_d       = 2'd0;
            st_d        = BK_PROBE;
          end else if (walk_busy_q) begin
            res_valid_d = 1'b1;
            kind_d      = KIND_DONE;
            mem_addr_d  = '0;
            fault_d     = 1'b0;
            mem_wd.valid = 1'b1;
            mem_wd.tag   = pend_va_q[VA_W-1:12];
            priority if (!head_item_i.read_ok || !dat[PRESENT_BIT]) begin
              fault_d     = 1'b1;
              phys_addr_d = '0;
              walk_busy_d = 1'b0;
              lvl_d       = 2'd0;
            end else if (lvl_q == 2'd1 && dat[LARGE_BIT]) begin
              phys_addr_d = {dat[51:30], pend_va_q[29:0]};
            end else if (lvl_q == 2'd2 && dat[LARGE_BIT]) begin
              phys_addr_d = {dat[51:21], pend_va_q[20:0]};
            end else if (lvl_q == 2'd3) begin
              phys_addr_d = {dat[51:12], pend_va_q[11:0]};
            end else begin
              kind_d      = KIND_READ;
              phys_addr_d = '0;
              lvl_d       = lvl_q + 1'b1;
              // next table base is 4 KiB aligned, so the index just drops in
              mem_addr_d  = {dat[51:12], level_idx(pend_va_q, lvl_q + 1'b1), 3'b000};
            end
            // any finished, non-faulting walk fills the cache
            if (kind_d == KIND_DONE && !fault_d) begin
              mem_we       = 1'b1;
              mem_wd.frame = phys_addr_d[PA_W-1:12];
              walk_busy_d  = 1'b0;
              lvl_d        = 2'd0;
            end
          end
        end
      end
      BK_PROBE: begin
        st_d        = BK_IDLE;
        res_valid_d = 1'b1;
        fault_d     = 1'b0;
        if (hit) begin
          kind_d      = KIND_DONE;
          mem_addr_d  = '0;
          phys_addr_d = {rd_q.frame, req_va_q[11:0]};
        end else begin
          kind_d      = KIND_READ;
          phys_addr_d = '0;
          mem_addr_d  = req_root_q + PA_W'({level_idx(req_va_q, 2'd0), 3'b000});
          pend_va_d   = req_va_q;
          pend_slot_d = req_slot_q;
          walk_busy_d = 1'b1;
          lvl_d       = 2'd0;
        end
      end
      default: st_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= BK_CLEAR;
      clr_q       <= '0;
      walk_busy_q <= 1'b0;
      lvl_q       <= 2'd0;
      pend_va_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      clr_q       <= clr_d;
      walk_busy_q <= walk_busy_d;
      lvl_q       <= lvl_d;
      pend_va_q   <= pend_va_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_slot_q <= pend_slot_d;
    req_va_q    <= req_va_d;
    req_root_q  <= req_root_d;
    req_slot_q  <= req_slot_d;
    kind_q      <= kind_d;
    mem_addr_q  <= mem_addr_d;
    phys_addr_q <= phys_addr_d;
    fault_q     <= fault_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) rd_q <= mem[mem_ra];
  end

  assign clearing_o  = (st_q == BK_CLEAR);
  assign res_valid_o = res_valid_q;
  assign kind_o      = kind_q;
  assign mem_addr_o  = mem_addr_q;
  assign phys_addr_o = phys_addr_q;
  assign fault_o     = fault_q;

  `PTW_ASSERT_NOW(a_read_needs_walk, res_valid_q && kind_q == KIND_READ, walk_busy_q)
  `PTW_ASSERT_NOW(a_quiet_in_clear, st_q == BK_CLEAR, !res_valid_q && !pop_o)
  `PTW_ASSERT_NEXT(a_probe_answers, st_q == BK_PROBE, res_valid_q && st_q == BK_IDLE)
  `PTW_ASSERT_NOW(a_fault_is_done, res_valid_q && fault_q, kind_q == KIND_DONE && phys_addr_q == '0)

endmodule

>>> design/page_table_walker_with_tlb.sv
// Top level of the four-level page table walker with translation cache.
// Depends on ptw_pkg, ptw_front, ptw_queue, ptw_back.
//
// A command beat is taken when start is high and busy low; op_i 0 asks for a
// translation of virt_addr_i, op_i 1 hands back a table entry for the outstanding
// read. Each beat yields at most one result, shown for a single cycle with
// res_valid_o high; the receiver cannot stall it and must take it then. kind_o 0
// asks for an 8-byte read at mem_addr_o, kind_o 1 ends the translation with
// phys_addr_o or fault_o. In the back end a request takes a cache memory read,
// then a compare; a data beat is handled in the idle state alone. A beat passes
// through the front's hold register and the queue before the back end, whose
// result registers drive the outputs. Beats that arrive while the back end works
// wait in a two-entry queue; busy stays high while that queue is full and the
// front holds a beat. For cache sizes that are not a power of two the slot of a
// request is a remainder worked out six page-number bits per cycle. After reset
// busy stays high while the cache valid bits are swept clear. A new request
// drops a walk in progress; data with no walk pending gives no result.
module page_table_walker_with_tlb #(
  parameter int CACHE_ENTRIES = ptw_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        op_i,
  input  logic [ptw_pkg::VA_W-1:0]    virt_addr_i,
  input  logic [ptw_pkg::PA_W-1:0]    root_table_i,
  input  logic [ptw_pkg::DATA_W-1:0]  read_data_i,
  input  logic                        read_ok_i,
  output logic                        res_valid_o,
  output logic                        kind_o,
  output logic [ptw_pkg::PA_W-1:0]    mem_addr_o,
  output logic [ptw_pkg::PA_W-1:0]    phys_addr_o,
  output logic                        fault_o
);
  import ptw_pkg::*;

  localparam int IDX_W = $clog2(CACHE_ENTRIES > 1 ? CACHE_ENTRIES : 2);

  item_t            in_item, push_item, head_item;
  logic [IDX_W-1:0] push_slot, head_slot;
  logic             accept, push, pop, front_busy, clearing;
  q_stat_t          q_stat;

  assign in_item.op         = op_i;
  assign in_item.virt_addr  = virt_addr_i;
  assign in_item.root_table = root_table_i;
  assign in_item.read_data  = read_data_i;
  assign in_item.read_ok    = read_ok_i;

  assign busy   = clearing || front_busy;
  assign accept = start && !busy;

  ptw_front #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_item),
    .q_full_i    (q_stat.full),
    .busy_o      (front_busy),
    .push_o      (push),
    .push_item_o (push_item),
    .push_slot_o (push_slot)
  );

  ptw_queue #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .push_slot_i (push_slot),
    .pop_i       (pop),
    .head_item_o (head_item),
    .head_slot_o (head_slot),
    .stat_o      (q_stat)
  );

  ptw_back #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .head_item_i (head_item),
    .head_slot_i (head_slot),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .res_valid_o (res_valid_o),
    .kind_o      (kind_o),
    .mem_addr_o  (mem_addr_o),
    .phys_addr_o (phys_addr_o),
    .fault_o     (fault_o)
  );

endmodule
